### rtl/core/dpalu_pkg.sv
// Package for the data-processing ALU core: item types, opcode and
// condition codes, and the condition check. No dependencies.
package dpalu_pkg;

    // Data-processing opcodes, instruction bits 24..21.
    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'ha,
        OP_CMN = 4'hb,
        OP_ORR = 4'hc,
        OP_MOV = 4'hd,
        OP_BIC = 4'he,
        OP_MVN = 4'hf
    } op_t;

    // Condition field, instruction bits 31..28.
    typedef enum logic [3:0] {
        CC_EQ = 4'h0,
        CC_NE = 4'h1,
        CC_CS = 4'h2,
        CC_CC = 4'h3,
        CC_MI = 4'h4,
        CC_PL = 4'h5,
        CC_VS = 4'h6,
        CC_VC = 4'h7,
        CC_HI = 4'h8,
        CC_LS = 4'h9,
        CC_GE = 4'ha,
        CC_LT = 4'hb,
        CC_GT = 4'hc,
        CC_LE = 4'hd,
        CC_AL = 4'he,
        CC_NV = 4'hf
    } cond_t;

    // Shift types, instruction bits 6..5.
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_t;

    localparam logic [3:0] PC_INDEX = 4'hf;

    // Flag bit positions within NZCV.
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // One input item as held in the input register.
    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] first_value;
        logic [31:0] shifted_value;
        logic [31:0] amount_value;
    } item_t;

    // One result item as held in the result register.
    typedef struct packed {
        logic [31:0] result;
        logic [3:0]  dest_index;
        logic        writes_dest;
        logic        condition_passed;
        logic [3:0]  flags_after;
        logic        restore_status;
        logic        writes_pc;
    } res_t;

    // Second operand and shifter carry-out.
    typedef struct packed {
        logic [31:0] operand;
        logic        carry;
    } shift_out_t;

    // Evaluates a condition field against NZCV flags.
    function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
        logic n;
        logic z;
        logic c;
        logic v;
        logic hold;
        n = f[FLAG_N];
        z = f[FLAG_Z];
        c = f[FLAG_C];
        v = f[FLAG_V];
        case (cond_t'(cond))
            CC_EQ:   hold = z;
            CC_NE:   hold = !z;
            CC_CS:   hold = c;
            CC_CC:   hold = !c;
            CC_MI:   hold = n;
            CC_PL:   hold = !n;
            CC_VS:   hold = v;
            CC_VC:   hold = !v;
            CC_HI:   hold = c && !z;
            CC_LS:   hold = !c || z;
            CC_GE:   hold = (n == v);
            CC_LT:   hold = (n != v);
            CC_GT:   hold = !z && (n == v);
            CC_LE:   hold = z || (n != v);
            CC_AL:   hold = 1'b1;
            default: hold = 1'b0;
        endcase
        return hold;
    endfunction

endpackage

### rtl/core/dpalu_if.sv
// Valid/ready channel interfaces for the data-processing ALU core.
// Depends on nothing; payload field widths follow the item definitions.

// Input channel: instruction word and the three register values.
interface dpalu_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] first_value;
    logic [31:0] shifted_value;
    logic [31:0] amount_value;

    modport source (
        output valid, instruction, first_value, shifted_value, amount_value,
        input  ready
    );
    modport sink (
        input  valid, instruction, first_value, shifted_value, amount_value,
        output ready
    );
endinterface

// Output channel: one result item per instruction.
interface dpalu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic [3:0]  dest_index;
    logic        writes_dest;
    logic        condition_passed;
    logic [3:0]  flags_after;
    logic        restore_status;
    logic        writes_pc;

    modport source (
        output valid, result, dest_index, writes_dest, condition_passed,
               flags_after, restore_status, writes_pc,
        input  ready
    );
    modport sink (
        input  valid, result, dest_index, writes_dest, condition_passed,
               flags_after, restore_status, writes_pc,
        output ready
    );
endinterface

### rtl/core/dpalu_shifter.sv
// Second-operand unit: rotated immediate or barrel shift with carry-out.
// Depends on dpalu_pkg.
module dpalu_shifter
    import dpalu_pkg::*;
(
    input  logic [31:0] instruction,
    input  logic [31:0] shifted_value,
    input  logic [7:0]  amount_byte,
    input  logic        cflag,
    output shift_out_t  shift_out
);

    logic        imm;
    logic        by_reg;
    logic [4:0]  rot;
    logic [63:0] imm_pair;
    logic [31:0] imm_rot;
    logic [31:0] v;
    logic [7:0]  amt;
    logic [5:0]  asr_amt;
    logic [32:0] lsl_wide;
    logic [32:0] lsr_wide;
    logic [32:0] asr_wide;
    logic [63:0] ror_pair;
    logic [31:0] ror_val;
    shift_t      sh_type;

    assign imm     = instruction[25];
    assign by_reg  = !imm && instruction[4];
    assign sh_type = shift_t'(instruction[6:5]);

    // Rotated 8-bit immediate.
    assign rot      = {instruction[11:8], 1'b0};
    assign imm_pair = {24'd0, instruction[7:0], 24'd0, instruction[7:0]} >> rot;
    assign imm_rot  = imm_pair[31:0];

    // Register-shift form sees R15 one word further on.
    assign v   = (by_reg && instruction[3:0] == PC_INDEX) ? shifted_value + 32'd4
                                                         : shifted_value;
    assign amt = by_reg ? amount_byte : {3'd0, instruction[11:7]};

    // Shift candidates; the extra bit carries the last bit shifted out.
    assign asr_amt  = (amt >= 8'd32) ? 6'd32 : amt[5:0];
    assign lsl_wide = {1'b0, v} << amt;
    assign lsr_wide = {v, 1'b0} >> amt;
    assign asr_wide = $signed({v, 1'b0}) >>> asr_amt;
    assign ror_pair = {v, v} >> amt[4:0];
    assign ror_val  = ror_pair[31:0];

    // Select operand and carry by form and shift type.
    always_comb
    begin
        shift_out.operand = v;
        shift_out.carry   = cflag;
        if (imm)
        begin
            shift_out.operand = imm_rot;
            shift_out.carry   = (rot == 5'd0) ? cflag : imm_rot[31];
        end
        else if (amt == 8'd0)
        begin
            // Zero amount: register form and LSL pass through; immediate
            // LSR and ASR mean a shift by 32, and ROR means RRX.
            if (!by_reg)
            begin
                case (sh_type)
                    SH_LSR:
                    begin
                        shift_out.operand = 32'd0;
                        shift_out.carry   = v[31];
                    end
                    SH_ASR:
                    begin
                        shift_out.operand = {32{v[31]}};
                        shift_out.carry   = v[31];
                    end
                    SH_ROR:
                    begin
                        shift_out.operand = {cflag, v[31:1]};
                        shift_out.carry   = v[0];
                    end
                    default:
                    begin
                        shift_out.operand = v;
                        shift_out.carry   = cflag;
                    end
                endcase
            end
        end
        else
        begin
            case (sh_type)
                SH_LSL:
                begin
                    shift_out.operand = lsl_wide[31:0];
                    shift_out.carry   = lsl_wide[32];
                end
                SH_LSR:
                begin
                    shift_out.operand = lsr_wide[32:1];
                    shift_out.carry   = lsr_wide[0];
                end
                SH_ASR:
                begin
                    shift_out.operand = asr_wide[32:1];
                    shift_out.carry   = asr_wide[0];
                end
                default:
                begin
                    shift_out.operand = ror_val;
                    shift_out.carry   = ror_val[31];
                end
            endcase
        end
    end

endmodule

### rtl/core/dpalu_exec.sv
// Condition check, ALU operation and flag update for one instruction.
// Depends on dpalu_pkg and dpalu_shifter.
module dpalu_exec
    import dpalu_pkg::*;
(
    input  item_t      item,
    input  logic [3:0] flags,
    output res_t       res
);

    shift_out_t  sh;
    op_t         op;
    logic        s_bit;
    logic        by_reg;
    logic [3:0]  rd;
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] sum;
    logic        add_v;
    logic        arith;
    logic [31:0] alu_out;
    logic        c_out;
    logic        v_out;
    logic        passed;
    logic        writes;
    logic        wpc;
    logic [3:0]  new_flags;

    assign op     = op_t'(item.instruction[24:21]);
    assign s_bit  = item.instruction[20];
    assign rd     = item.instruction[15:12];
    assign by_reg = !item.instruction[25] && item.instruction[4];

    dpalu_shifter u_shifter (
        .instruction   (item.instruction),
        .shifted_value (item.shifted_value),
        .amount_byte   (item.amount_value[7:0]),
        .cflag         (flags[FLAG_C]),
        .shift_out     (sh)
    );

    assign right = sh.operand;
    assign left  = (by_reg && item.instruction[19:16] == PC_INDEX)
                   ? item.first_value + 32'd4 : item.first_value;

    // Adder operand selection; one adder serves all arithmetic opcodes.
    always_comb
    begin
        add_a   = left;
        add_b   = right;
        add_cin = 1'b0;
        arith   = 1'b1;
        case (op)
            OP_SUB, OP_CMP:
            begin
                add_b   = ~right;
                add_cin = 1'b1;
            end
            OP_RSB:
            begin
                add_a   = right;
                add_b   = ~left;
                add_cin = 1'b1;
            end
            OP_ADD, OP_CMN:
            begin
                add_cin = 1'b0;
            end
            OP_ADC:
            begin
                add_cin = flags[FLAG_C];
            end
            OP_SBC:
            begin
                add_b   = ~right;
                add_cin = flags[FLAG_C];
            end
            OP_RSC:
            begin
                add_a   = right;
                add_b   = ~left;
                add_cin = flags[FLAG_C];
            end
            default:
            begin
                arith = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    assign add_v = ((add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]));

    // Logical results; these keep the shifter carry and leave V alone.
    always_comb
    begin
        case (op)
            OP_AND, OP_TST: alu_out = left & right;
            OP_EOR, OP_TEQ: alu_out = left ^ right;
            OP_ORR:         alu_out = left | right;
            OP_MOV:         alu_out = right;
            OP_BIC:         alu_out = left & ~right;
            OP_MVN:         alu_out = ~right;
            default:        alu_out = sum[31:0];
        endcase
    end

    assign c_out = arith ? sum[32] : sh.carry;
    assign v_out = arith ? add_v : flags[FLAG_V];

    // Condition, destination write and status-restore decisions.
    assign passed = cond_holds(item.instruction[31:28], flags);
    assign writes = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
    assign wpc    = passed && writes && (rd == PC_INDEX);

    always_comb
    begin
        new_flags = flags;
        if (passed && s_bit && !wpc)
        begin
            new_flags[FLAG_N] = alu_out[31];
            new_flags[FLAG_Z] = (alu_out == 32'd0);
            new_flags[FLAG_C] = c_out;
            new_flags[FLAG_V] = v_out;
        end
    end

    assign res.result           = passed ? alu_out : 32'd0;
    assign res.dest_index       = rd;
    assign res.writes_dest      = passed && writes;
    assign res.condition_passed = passed;
    assign res.flags_after      = new_flags;
    assign res.restore_status   = wpc && s_bit;
    assign res.writes_pc        = wpc;

endmodule

### rtl/core/arm_data_processing_alu_core.sv
// Data-processing execute core: input register, single-pass ALU, result register.
// Depends on dpalu_pkg, dpalu_if and dpalu_exec.
//
// Use: an instruction item enters on the req channel with the values of Rn, Rm
// and Rs; one result item per instruction leaves on the rsp channel. Both are
// valid/ready handshakes; an item moves on a clock edge where both are high.
// An accepted item is held in the input register, passes the shifter, ALU and
// flag logic combinationally, and is loaded into the result register once that
// register is free. Throughput is one item per cycle while rsp.ready stays high.
// The NZCV flags register is written when an item moves into the result
// register, so the next item in the input register already sees the flags
// its predecessor left.
// When the receiver stalls, the result register holds its item and the input
// register keeps taking one more item; once both are full, req.ready drops
// until rsp.ready returns.
// Reset clears both valid bits and the NZCV flags to zero.
module arm_data_processing_alu_core
    import dpalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dpalu_in_if.sink    req,
    dpalu_out_if.source rsp
);

    logic       stage_valid_reg;
    logic       stage_valid_next;
    item_t      item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       res_reg;
    res_t       exec_res;
    logic [3:0] flags_reg;
    logic [3:0] flags_next;
    logic       out_free;
    logic       load_out;
    logic       in_fire;

    // Handshake control for the two register stages.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign load_out  = stage_valid_reg && out_free;
    assign req.ready = !stage_valid_reg || out_free;
    assign in_fire   = req.valid && req.ready;

    dpalu_exec u_exec (
        .item  (item_reg),
        .flags (flags_reg),
        .res   (exec_res)
    );

    // Next-state logic for valid bits and flags.
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (load_out)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        flags_next = load_out ? exec_res.flags_after : flags_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            flags_reg       <= 4'd0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            flags_reg       <= flags_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.instruction   <= req.instruction;
            item_reg.first_value   <= req.first_value;
            item_reg.shifted_value <= req.shifted_value;
            item_reg.amount_value  <= req.amount_value;
        end
        if (load_out)
        begin
            res_reg <= exec_res;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.result           = res_reg.result;
    assign rsp.dest_index       = res_reg.dest_index;
    assign rsp.writes_dest      = res_reg.writes_dest;
    assign rsp.condition_passed = res_reg.condition_passed;
    assign rsp.flags_after      = res_reg.flags_after;
    assign rsp.restore_status   = res_reg.restore_status;
    assign rsp.writes_pc        = res_reg.writes_pc;

    // The flags register always matches the flags of the last result loaded.
    a_flags_follow_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> flags_reg == res_reg.flags_after)
        else $error("flags register differs from last result flags");

    // Flags change only when an item moves into the result register.
    a_flags_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !load_out |=> $stable(flags_reg))
        else $error("flags changed without an item completing");

    // A failed condition writes nothing and leaves a zero result.
    a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.condition_passed |->
            !res_reg.writes_dest && !res_reg.writes_pc && !res_reg.restore_status
            && res_reg.result == 32'd0)
        else $error("failed condition produced a write");

    // A status restore happens only on a PC write and keeps the flags.
    a_restore_on_pc: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && exec_res.restore_status |->
            exec_res.writes_pc && exec_res.flags_after == flags_reg)
        else $error("status restore without PC write or with flag change");

endmodule

### verif/tb_arm_data_processing_alu_core.sv
`timescale 1ns / 1ps
// Testbench for arm_data_processing_alu_core: directed and random instruction items are
// checked against an in-bench model of the condition check, shifter, ALU and NZCV flags.
// Depends on dpalu_pkg, the dpalu_in_if/dpalu_out_if interfaces and the core RTL.
module tb_arm_data_processing_alu_core;
    import dpalu_pkg::*;

    localparam int RANDOM_ITEMS    = 1100;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int IDLE_PERCENT    = 18;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int CALM_FROM       = 600;
    localparam int CALM_TO         = 800;

    // Sum, carry-out and signed overflow of one adder pass.
    typedef struct packed {
        logic [31:0] sum;
        logic        c;
        logic        v;
    } add_out_t;

    logic clk;
    logic rst_n;

    dpalu_in_if  req_ch ();
    dpalu_out_if rsp_ch ();

    arm_data_processing_alu_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    item_t       stimulus_items[$];
    res_t        expected_results[$];
    logic [3:0]  model_flags = '0;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          results_seen = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          req_fire = 1'b0;
    logic [31:0] corner_vals [4] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};

    // Free-running clock, 8 ns period.
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Execute model
    // ------------------------------------------------------------------

    function automatic logic [31:0] ror_word(logic [31:0] v, logic [4:0] r);
        logic [63:0] d;
        d = {v, v} >> r;
        return d[31:0];
    endfunction

    function automatic bit cond_met(logic [3:0] cc, logic [3:0] f);
        bit n;
        bit z;
        bit c;
        bit v;
        bit ok;
        n = f[FLAG_N];
        z = f[FLAG_Z];
        c = f[FLAG_C];
        v = f[FLAG_V];
        case (cond_t'(cc))
            CC_EQ:   ok = z;
            CC_NE:   ok = !z;
            CC_CS:   ok = c;
            CC_CC:   ok = !c;
            CC_MI:   ok = n;
            CC_PL:   ok = !n;
            CC_VS:   ok = v;
            CC_VC:   ok = !v;
            CC_HI:   ok = c && !z;
            CC_LS:   ok = !c || z;
            CC_GE:   ok = (n == v);
            CC_LT:   ok = (n != v);
            CC_GT:   ok = !z && (n == v);
            CC_LE:   ok = z || (n != v);
            CC_AL:   ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Barrel shifter; imm_form selects the immediate-amount encodings of a zero shift.
    function automatic shift_out_t barrel_shift(logic [31:0] v, shift_t kind, int amt,
                                                bit imm_form, bit cin);
        shift_out_t so;
        logic [31:0] r;
        so.operand = v;
        so.carry   = cin;
        if (amt == 0)
        begin
            if (imm_form)
            begin
                case (kind)
                    SH_LSL:
                    begin
                        so.operand = v;
                    end
                    SH_LSR:
                    begin
                        so.operand = '0;
                        so.carry   = v[31];
                    end
                    SH_ASR:
                    begin
                        so.operand = {32{v[31]}};
                        so.carry   = v[31];
                    end
                    default:
                    begin
                        so.operand = {cin, v[31:1]};
                        so.carry   = v[0];
                    end
                endcase
            end
        end
        else
        begin
            case (kind)
                SH_LSL:
                begin
                    if (amt < 32)
                    begin
                        so.operand = v << amt;
                        so.carry   = v[32 - amt];
                    end
                    else
                    begin
                        so.operand = '0;
                        so.carry   = (amt == 32) ? v[0] : 1'b0;
                    end
                end
                SH_LSR:
                begin
                    if (amt < 32)
                    begin
                        so.operand = v >> amt;
                        so.carry   = v[amt - 1];
                    end
                    else
                    begin
                        so.operand = '0;
                        so.carry   = (amt == 32) ? v[31] : 1'b0;
                    end
                end
                SH_ASR:
                begin
                    if (amt >= 32)
                    begin
                        so.operand = {32{v[31]}};
                        so.carry   = v[31];
                    end
                    else
                    begin
                        so.operand = $signed(v) >>> amt;
                        so.carry   = v[amt - 1];
                    end
                end
                default:
                begin
                    r = ror_word(v, amt[4:0]);
                    so.operand = r;
                    so.carry   = r[31];
                end
            endcase
        end
        return so;
    endfunction

    function automatic add_out_t add_carry(logic [31:0] a, logic [31:0] b, logic cin);
        add_out_t ad;
        logic [32:0] wide;
        wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        ad.sum = wide[31:0];
        ad.c   = wide[32];
        ad.v   = (a[31] ^ wide[31]) & (b[31] ^ wide[31]);
        return ad;
    endfunction

    // Executes one instruction item against the model flags and returns its result item.
    function automatic res_t execute_model(logic [31:0] ins, logic [31:0] lhs_in,
                                           logic [31:0] rm_in, logic [31:0] rs_in);
        res_t        r;
        logic [31:0] lhs;
        logic [31:0] rmv;
        logic [31:0] rhs;
        logic [31:0] value;
        shift_out_t  so;
        add_out_t    ad;
        op_t         op;
        logic [3:0]  rd;
        logic [3:0]  nf;
        int          rot;
        bit          by_reg;
        bit          passed;
        bit          cflag;
        bit          carry;
        bit          ovf;
        bit          arith;
        bit          writes;
        bit          wpc;
        bit          restore;

        op      = op_t'(ins[24:21]);
        rd      = ins[15:12];
        by_reg  = !ins[25] && ins[4];
        cflag   = model_flags[FLAG_C];
        ovf     = model_flags[FLAG_V];
        passed  = cond_met(ins[31:28], model_flags);
        lhs     = lhs_in;
        rmv     = rm_in;
        wpc     = 1'b0;
        restore = 1'b0;

        // Second operand: rotated immediate or shifted register.
        if (ins[25])
        begin
            rot = ins[11:8] * 2;
            so.operand = ror_word({24'd0, ins[7:0]}, rot[4:0]);
            so.carry   = (rot == 0) ? cflag : so.operand[31];
        end
        else
        begin
            if (by_reg && ins[3:0] == PC_INDEX)
                rmv = rmv + 32'd4;
            if (by_reg)
                so = barrel_shift(rmv, shift_t'(ins[6:5]), int'(rs_in[7:0]), 1'b0, cflag);
            else
                so = barrel_shift(rmv, shift_t'(ins[6:5]), int'(ins[11:7]), 1'b1, cflag);
        end
        if (by_reg && ins[19:16] == PC_INDEX)
            lhs = lhs + 32'd4;
        rhs   = so.operand;
        carry = so.carry;

        // ALU operation.
        arith = 1'b1;
        case (op)
            OP_SUB, OP_CMP: ad = add_carry(lhs, ~rhs, 1'b1);
            OP_RSB:         ad = add_carry(rhs, ~lhs, 1'b1);
            OP_ADD, OP_CMN: ad = add_carry(lhs, rhs, 1'b0);
            OP_ADC:         ad = add_carry(lhs, rhs, cflag);
            OP_SBC:         ad = add_carry(lhs, ~rhs, cflag);
            OP_RSC:         ad = add_carry(rhs, ~lhs, cflag);
            default:        arith = 1'b0;
        endcase
        if (arith)
        begin
            value = ad.sum;
            carry = ad.c;
            ovf   = ad.v;
        end
        else
        begin
            case (op)
                OP_AND, OP_TST: value = lhs & rhs;
                OP_EOR, OP_TEQ: value = lhs ^ rhs;
                OP_ORR:         value = lhs | rhs;
                OP_MOV:         value = rhs;
                OP_BIC:         value = lhs & ~rhs;
                default:        value = ~rhs;
            endcase
        end
        writes = (op != OP_TST) && (op != OP_TEQ) && (op != OP_CMP) && (op != OP_CMN);

        // Flag update, or a status restore when R15 is written with S.
        if (passed)
        begin
            wpc = writes && (rd == PC_INDEX);
            if (ins[20])
            begin
                if (wpc)
                    restore = 1'b1;
                else
                begin
                    nf = '0;
                    nf[FLAG_N] = value[31];
                    nf[FLAG_Z] = (value == 32'd0);
                    nf[FLAG_C] = carry;
                    nf[FLAG_V] = ovf;
                    model_flags = nf;
                end
            end
        end
        else
        begin
            value  = '0;
            writes = 1'b0;
        end

        r.result           = value;
        r.dest_index       = rd;
        r.writes_dest      = writes;
        r.condition_passed = passed;
        r.flags_after      = model_flags;
        r.restore_status   = restore;
        r.writes_pc        = wpc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [31:0] dp_word(cond_t cc, bit imm, op_t op, bit s,
                                            logic [3:0] rn, logic [3:0] rd, logic [11:0] op2);
        return {cc, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    function automatic logic [11:0] sh_imm(logic [4:0] amt, shift_t kind, logic [3:0] rm);
        return {amt, kind, 1'b0, rm};
    endfunction

    function automatic logic [11:0] sh_reg(logic [3:0] rs, shift_t kind, logic [3:0] rm);
        return {rs, 1'b0, kind, 1'b1, rm};
    endfunction

    // Mostly random words, with the corner values a quarter of the time.
    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 3) == 0)
            return corner_vals[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    // No idling inside the calm window; elsewhere idle about IDLE_PERCENT of cycles.
    function automatic bit skip_cycle();
        if (results_seen >= CALM_FROM && results_seen < CALM_TO)
            return 1'b0;
        return ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    task automatic queue_item(logic [31:0] ins, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        stimulus_items.push_back('{instruction: ins, first_value: a, shifted_value: b,
                                   amount_value: c});
        items_queued++;
    endtask

    task automatic check_result(res_t exp, res_t got);
        if (got.result !== exp.result)
        begin
            $error("result: expected %h, got %h", exp.result, got.result);
            error_count++;
        end
        if (got.dest_index !== exp.dest_index)
        begin
            $error("dest_index: expected %h, got %h", exp.dest_index, got.dest_index);
            error_count++;
        end
        if (got.writes_dest !== exp.writes_dest)
        begin
            $error("writes_dest: expected %b, got %b", exp.writes_dest, got.writes_dest);
            error_count++;
        end
        if (got.condition_passed !== exp.condition_passed)
        begin
            $error("condition_passed: expected %b, got %b",
                   exp.condition_passed, got.condition_passed);
            error_count++;
        end
        if (got.flags_after !== exp.flags_after)
        begin
            $error("flags_after: expected %h, got %h", exp.flags_after, got.flags_after);
            error_count++;
        end
        if (got.restore_status !== exp.restore_status)
        begin
            $error("restore_status: expected %b, got %b", exp.restore_status, got.restore_status);
            error_count++;
        end
        if (got.writes_pc !== exp.writes_pc)
        begin
            $error("writes_pc: expected %b, got %b", exp.writes_pc, got.writes_pc);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------

    // Offer the next pending item once the current one has gone, or idle.
    always @(negedge clk)
    begin : drive_req
        item_t nxt;
        if (rst_n && (!req_ch.valid || req_fire))
        begin
            if (stimulus_items.size() > 0 && !skip_cycle())
            begin
                nxt = stimulus_items.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.instruction   <= nxt.instruction;
                req_ch.first_value   <= nxt.first_value;
                req_ch.shifted_value <= nxt.shifted_value;
                req_ch.amount_value  <= nxt.amount_value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result-side ready, with one long hold-off so that the core backs up.
    always @(negedge clk)
    begin : drive_rsp_ready
        if (rst_n)
        begin
            if (!hold_done && results_seen >= HOLD_OFF_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !skip_cycle();
        end
    end

    // Sample both handshakes, predict accepted items, check results, and watch for hangs.
    always @(posedge clk)
    begin : monitor
        res_t got;
        bit   rsp_fire;
        if (rst_n)
        begin
            req_fire = req_ch.valid && req_ch.ready;
            rsp_fire = rsp_ch.valid && rsp_ch.ready;
            if (req_fire)
            begin
                expected_results.push_back(execute_model(req_ch.instruction, req_ch.first_value,
                                                         req_ch.shifted_value,
                                                         req_ch.amount_value));
                items_accepted++;
            end
            if (rsp_fire)
            begin
                got = '{result: rsp_ch.result, dest_index: rsp_ch.dest_index,
                        writes_dest: rsp_ch.writes_dest,
                        condition_passed: rsp_ch.condition_passed,
                        flags_after: rsp_ch.flags_after,
                        restore_status: rsp_ch.restore_status,
                        writes_pc: rsp_ch.writes_pc};
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: result %h", got.result);
                    error_count++;
                end
                else
                    check_result(expected_results.pop_front(), got);
            end
            if (req_fire || rsp_fire)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : sequence_main
        logic [31:0] ins;
        logic [31:0] amount;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.instruction   = '0;
        req_ch.first_value   = '0;
        req_ch.shifted_value = '0;
        req_ch.amount_value  = '0;
        rsp_ch.ready         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every opcode with S set, over the corner operand values.
        for (int i = 0; i < 16; i++)
        begin
            queue_item(dp_word(CC_AL, 1'b0, op_t'(i[3:0]), 1'b1, 4'd1, 4'd2,
                               sh_imm(5'd0, SH_LSL, 4'd3)),
                       corner_vals[i % 4], corner_vals[(i / 4) % 4], 32'd0);
        end
        // Immediate shift of zero: LSR and ASR by 32, ROR as RRX.
        queue_item(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd4, sh_imm(5'd0, SH_LSR, 4'd5)),
                   32'd0, 32'h8000_0001, 32'd0);
        queue_item(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd4, sh_imm(5'd0, SH_ASR, 4'd5)),
                   32'd0, 32'h8000_0000, 32'd0);
        queue_item(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd4, sh_imm(5'd0, SH_ROR, 4'd5)),
                   32'd0, 32'h0000_0003, 32'd0);
        // Register shifts by zero, by exactly 32 and by the largest amount.
        queue_item(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd4, sh_reg(4'd6, SH_ROR, 4'd5)),
                   32'd0, 32'h1234_5678, 32'hffff_ff00);
        queue_item(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd4, sh_reg(4'd6, SH_LSL, 4'd5)),
                   32'd0, 32'h0000_0001, 32'h0000_0020);
        queue_item(dp_word(CC_AL, 1'b0, OP_ORR, 1'b1, 4'd1, 4'd4, sh_reg(4'd6, SH_LSR, 4'd5)),
                   32'h0000_0000, 32'hffff_ffff, 32'h0000_00ff);
        // R15 as both Rn and Rm under a register shift reads four higher.
        queue_item(dp_word(CC_AL, 1'b0, OP_ADD, 1'b1, PC_INDEX, 4'd3,
                           sh_reg(4'd6, SH_LSL, PC_INDEX)),
                   32'h0000_1008, 32'h0000_1008, 32'h0000_0001);
        // Rotated immediate with the largest rotation.
        queue_item(dp_word(CC_AL, 1'b1, OP_ORR, 1'b1, 4'd1, 4'd2, {4'hf, 8'hff}),
                   32'h0000_0000, 32'd0, 32'd0);
        // S with R15 written restores status; a compare with Rd of R15 still sets flags.
        queue_item(dp_word(CC_AL, 1'b0, OP_SUB, 1'b1, 4'd14, PC_INDEX, sh_imm(5'd0, SH_LSL, 4'd3)),
                   32'h0000_0010, 32'h0000_0010, 32'd0);
        queue_item(dp_word(CC_AL, 1'b0, OP_CMP, 1'b1, 4'd1, PC_INDEX, sh_imm(5'd0, SH_LSL, 4'd3)),
                   32'h0000_0001, 32'h0000_0002, 32'd0);
        // Condition field NV never passes.
        queue_item(dp_word(CC_NV, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd1, sh_imm(5'd0, SH_LSL, 4'd3)),
                   32'd0, 32'hffff_ffff, 32'd0);

        // Hold the sender until every directed result has come back.
        wait (items_accepted == items_queued);
        wait (results_seen == items_accepted);

        // Random items, biased toward R15, zero shift fields and boundary amounts.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            ins = $urandom();
            if ($urandom_range(0, 3) == 0)
                ins[31:28] = CC_AL;
            if ($urandom_range(0, 7) == 0)
                ins[15:12] = PC_INDEX;
            if ($urandom_range(0, 7) == 0)
                ins[19:16] = PC_INDEX;
            if ($urandom_range(0, 7) == 0)
                ins[3:0] = PC_INDEX;
            if (!ins[25] && !ins[4] && $urandom_range(0, 3) == 0)
                ins[11:7] = 5'd0;
            amount = $urandom();
            case ($urandom_range(0, 3))
                0:       amount[7:0] = 8'd0;
                1:       amount[7:0] = 8'd32;
                2:       amount[7:0] = 8'($urandom_range(1, 31));
                default: amount[7:0] = amount[7:0];
            endcase
            queue_item(ins, pick_word(), pick_word(), amount);
        end

        // Drain and report.
        wait (items_accepted == items_queued);
        wait (results_seen == items_accepted);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
